>>> sv/utf8tv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8tv_pkg: shared types and constants of the UTF-8 text validator
// Byte boundaries of strict UTF-8, the register reset value and the
// per-string sequence state that travels between the top level and the step.
// ----------------------------------------------------------------------------
package utf8tv_pkg;

  localparam int COUNT_WIDTH_DEF = 11;
  localparam int MAX_W           = 10;
  localparam logic [MAX_W-1:0] MAX_RESET = 10'd160;

  // Byte boundaries.
  localparam logic [7:0] BYTE_SPACE      = 8'h20;
  localparam logic [7:0] BYTE_DEL        = 8'h7F;
  localparam logic [7:0] LEAD2_LO        = 8'hC2;
  localparam logic [7:0] LEAD2_HI        = 8'hDF;
  localparam logic [7:0] LEAD3_LO        = 8'hE0;
  localparam logic [7:0] LEAD3_HI        = 8'hEF;
  localparam logic [7:0] LEAD4_LO        = 8'hF0;
  localparam logic [7:0] LEAD4_HI        = 8'hF4;
  localparam logic [7:0] LEAD_SURROGATE  = 8'hED;
  localparam logic [7:0] E0_SECOND_MIN   = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX   = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN   = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX   = 8'h8F;

  // Continuation bytes still expected after each kind of lead byte.
  localparam logic [1:0] CONT_NONE  = 2'd0;
  localparam logic [1:0] CONT_TWO   = 2'd1;
  localparam logic [1:0] CONT_THREE = 2'd2;
  localparam logic [1:0] CONT_FOUR  = 2'd3;

  typedef struct packed {
    logic [1:0] cont_left;
    logic [7:0] lead_byte;
    logic       expect_second;
    logic       failed;
    logic       any_seen;
  } seq_state_t;

  localparam seq_state_t SEQ_CLEAR = '{cont_left: CONT_NONE, lead_byte: 8'h00,
                                       expect_second: 1'b0, failed: 1'b0,
                                       any_seen: 1'b0};

endpackage

>>> sv/utf8tv_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8tv_step: one byte of UTF-8 checking
// Takes the current sequence state and one item and returns the next state,
// the next code-point count and the verdict for a final item.
// ----------------------------------------------------------------------------
module utf8tv_step #(
  parameter int COUNT_WIDTH = utf8tv_pkg::COUNT_WIDTH_DEF
) (
  input  utf8tv_pkg::seq_state_t        state_cur,
  input  logic [COUNT_WIDTH-1:0]        count_cur,
  input  logic [utf8tv_pkg::MAX_W-1:0]  max_points,
  input  logic [7:0]                    text_byte,
  input  logic                          byte_present,
  input  logic                          last_item,
  output utf8tv_pkg::seq_state_t        state_nxt,
  output logic [COUNT_WIDTH-1:0]        count_nxt,
  output logic [COUNT_WIDTH-1:0]        count_upd,
  output logic                          text_valid
);

  localparam int CMP_W = (COUNT_WIDTH > utf8tv_pkg::MAX_W) ? COUNT_WIDTH : utf8tv_pkg::MAX_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  utf8tv_pkg::seq_state_t upd;
  logic [COUNT_WIDTH-1:0] cnt_upd;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   point_done;
  logic                   bad;
  logic                   bad_second;

  assign cnt_inc  = (count_cur == COUNT_MAX) ? count_cur : count_cur + 1'b1;

  // The count after this byte, before any end-of-string clear.
  assign count_upd = cnt_upd;

  assign bad_second =
      (state_cur.lead_byte == utf8tv_pkg::LEAD3_LO &&
       text_byte < utf8tv_pkg::E0_SECOND_MIN) ||
      (state_cur.lead_byte == utf8tv_pkg::LEAD_SURROGATE &&
       text_byte > utf8tv_pkg::ED_SECOND_MAX) ||
      (state_cur.lead_byte == utf8tv_pkg::LEAD4_LO &&
       text_byte < utf8tv_pkg::F0_SECOND_MIN) ||
      (state_cur.lead_byte == utf8tv_pkg::LEAD4_HI &&
       text_byte > utf8tv_pkg::F4_SECOND_MAX);

  always_comb begin
    upd        = state_cur;
    point_done = 1'b0;
    bad        = 1'b0;
    if (byte_present) begin
      upd.any_seen = 1'b1;
      if (!state_cur.failed) begin
        if (state_cur.cont_left == utf8tv_pkg::CONT_NONE) begin
          priority if (text_byte <= utf8tv_pkg::BYTE_DEL) begin
            if (text_byte < utf8tv_pkg::BYTE_SPACE || text_byte == utf8tv_pkg::BYTE_DEL) begin
              bad = 1'b1;
            end else begin
              point_done = 1'b1;
            end
          end else if (text_byte >= utf8tv_pkg::LEAD2_LO && text_byte <= utf8tv_pkg::LEAD2_HI) begin
            upd.cont_left     = utf8tv_pkg::CONT_TWO;
            upd.lead_byte     = text_byte;
            upd.expect_second = 1'b1;
          end else if (text_byte >= utf8tv_pkg::LEAD3_LO && text_byte <= utf8tv_pkg::LEAD3_HI) begin
            upd.cont_left     = utf8tv_pkg::CONT_THREE;
            upd.lead_byte     = text_byte;
            upd.expect_second = 1'b1;
          end else if (text_byte >= utf8tv_pkg::LEAD4_LO && text_byte <= utf8tv_pkg::LEAD4_HI) begin
            upd.cont_left     = utf8tv_pkg::CONT_FOUR;
            upd.lead_byte     = text_byte;
            upd.expect_second = 1'b1;
          end else begin
            bad = 1'b1;
          end
        end else if (text_byte[7:6] != 2'b10) begin
          bad = 1'b1;
        end else if (state_cur.expect_second && bad_second) begin
          bad = 1'b1;
        end else begin
          upd.expect_second = 1'b0;
          upd.cont_left     = state_cur.cont_left - 2'd1;
          point_done        = (state_cur.cont_left == utf8tv_pkg::CONT_TWO);
        end
      end
    end

    cnt_upd = count_cur;
    if (point_done) begin
      cnt_upd = cnt_inc;
      if (CMP_W'(cnt_inc) > CMP_W'(max_points)) begin
        bad = 1'b1;
      end
    end
    upd.failed = upd.failed | bad;

    text_valid = !upd.failed && upd.any_seen && (upd.cont_left == utf8tv_pkg::CONT_NONE);

    if (last_item) begin
      state_nxt = utf8tv_pkg::SEQ_CLEAR;
      count_nxt = '0;
    end else begin
      state_nxt = upd;
      count_nxt = cnt_upd;
    end
  end

endmodule

>>> sv/utf8_text_validator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_validator_unit: strict UTF-8 text checker, one byte per clock unless a final item stalls
// Checks a byte stream for strict UTF-8 printable text, counts code points
// against a programmable limit and reports one verdict per string.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  tdata / tuser / tlast                       Handshake
//   in_      slave      text_byte / byte_present / last_item         tvalid, tready
//   out_     master     {code_points, text_valid} / none / none      tvalid, tready
//   cfg_     write      cfg_wr_data = max_code_points                cfg_wr_en
//
// One input transaction per clock while no final item stalls: a transaction
// lands in the input register and is checked there against the per-string
// state. A final item's verdict goes from the input register into the result
// register, which drives out_tvalid.
// Only a final item stalls: it waits in the input register, and blocks the
// input, while the previous verdict is still unaccepted.
// rst_n (synchronous) clears both valid flags, the state and the count, and
// sets the limit to 160.
//
module utf8_text_validator_unit #(
  parameter int COUNT_WIDTH = utf8tv_pkg::COUNT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] text_byte
  input  logic                         in_tuser,   // [0] byte_present
  input  logic                         in_tlast,   // last_item
  // Result stream.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [((COUNT_WIDTH+8)/8)*8-1:0] out_tdata, // [0] text_valid, then code_points
  // Configuration.
  input  logic                         cfg_wr_en,
  input  logic [utf8tv_pkg::MAX_W-1:0] cfg_wr_data  // max_code_points
);

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_present_r;
  logic       in_last_r;

  // Per-string state and the limit register.
  utf8tv_pkg::seq_state_t        state_r;
  utf8tv_pkg::seq_state_t        state_nxt;
  logic [COUNT_WIDTH-1:0]        count_r;
  logic [COUNT_WIDTH-1:0]        count_nxt;
  logic [COUNT_WIDTH-1:0]        count_upd;
  logic [utf8tv_pkg::MAX_W-1:0]  max_r;

  // Result register.
  logic                   out_valid_r;
  logic                   out_text_valid_r;
  logic [COUNT_WIDTH-1:0] out_count_r;

  logic step_valid;
  logic advance;

  // The held item moves through the checker unless it is a final item and
  // the result register is still occupied by a verdict nobody took.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  utf8tv_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .state_cur    (state_r),
    .count_cur    (count_r),
    .max_points   (max_r),
    .text_byte    (in_byte_r),
    .byte_present (in_present_r),
    .last_item    (in_last_r),
    .state_nxt    (state_nxt),
    .count_nxt    (count_nxt),
    .count_upd    (count_upd),
    .text_valid   (step_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r    <= in_tdata;
      in_present_r <= in_tuser;
      in_last_r    <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= utf8tv_pkg::MAX_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= utf8tv_pkg::SEQ_CLEAR;
      count_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // The verdict uses the count before the end-of-string clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_text_valid_r <= step_valid;
      out_count_r      <= count_upd;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                = '0;
    out_tdata[0]             = out_text_valid_r;
    out_tdata[COUNT_WIDTH:1] = out_count_r;
  end

endmodule

>>> sv/utf8tv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8tv_checker: port-level checks of the UTF-8 text validator
// Tracks the limit register from the write port and checks the verdicts and
// the flow control seen on the streams.
// ----------------------------------------------------------------------------
module utf8tv_checker #(
  parameter int COUNT_WIDTH = utf8tv_pkg::COUNT_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [((COUNT_WIDTH+8)/8)*8-1:0]  out_tdata,
  input logic                              cfg_wr_en,
  input logic [utf8tv_pkg::MAX_W-1:0]      cfg_wr_data
);

  localparam int CMP_W = ((COUNT_WIDTH > utf8tv_pkg::MAX_W) ? COUNT_WIDTH : utf8tv_pkg::MAX_W) + 1;

  logic [utf8tv_pkg::MAX_W-1:0] max_r;
  logic [CMP_W-1:0]             count_ext;
  logic [CMP_W-1:0]             max_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= utf8tv_pkg::MAX_RESET;
    end else if (cfg_wr_en) begin
      max_r <= cfg_wr_data;
    end
  end

  assign count_ext = CMP_W'(out_tdata[COUNT_WIDTH:1]);
  assign max_ext   = CMP_W'(max_r);

  // The count never passes the limit by more than one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> count_ext <= max_ext + 1'b1)
    else $error("code point count above limit plus one");

  // A valid string holds at least one code point and stays within the limit.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (count_ext != '0 && count_ext <= max_ext))
    else $error("valid verdict with an impossible count");

  // With the result register empty, the input side is never stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with no verdict pending");

  // The first cycle out of reset shows no verdict.
  assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_tvalid)
    else $error("verdict present right after reset");

  // A stalled verdict holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("verdict dropped or changed while stalled");

endmodule

bind utf8_text_validator_unit utf8tv_checker #(
  .COUNT_WIDTH (COUNT_WIDTH)
) u_utf8tv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .cfg_wr_en   (cfg_wr_en),
  .cfg_wr_data (cfg_wr_data)
);
